/* rtl/cartridge_bank_mapper_irq_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Shared property shorthands. They sample on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// Same-cycle implication.
`define CBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// Next-cycle implication.
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

/* rtl/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, register indexes and widths shared by the bank mapper modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int MAX_PRG_BANKS = 256;
  localparam int BANK_W        = $clog2(MAX_PRG_BANKS);
  localparam int COUNT_W       = BANK_W + 1;
  localparam int ADDR_W        = 15;
  localparam int MAP_W         = 22;
  localparam int PRG_OFS_W     = 14;
  localparam int CHR_OFS_W     = 10;
  localparam int CHR_SLOTS     = 8;
  localparam int SLOT_W        = $clog2(CHR_SLOTS);
  localparam int CTR_W         = 16;
  localparam int OUTQ_DEPTH    = 3;
  localparam int OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [3:0] REG_PRG_BANK  = 4'd8;
  localparam logic [3:0] REG_MIRROR    = 4'd9;
  localparam logic [3:0] REG_IRQ_CTRL  = 4'd10;
  localparam logic [3:0] REG_CTR_LOW   = 4'd11;
  localparam logic [3:0] REG_CTR_HIGH  = 4'd12;

  localparam logic [3:0] CFG_PRG_BANK_COUNT = 4'd0;
  localparam logic [3:0] CFG_CHR_FROM_ROM   = 4'd1;

  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = COUNT_W'(8);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_PRG   = 2'd2,
    KIND_CHR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        reg_index;
    logic [7:0]        write_data;
    logic [ADDR_W-1:0] bus_address;
  } item_t;

  typedef struct packed {
    logic             irq_line;
    logic [MAP_W-1:0] mapped_address;
    logic [1:0]       mirroring;
    logic             chr_in_rom;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prg_bank_count;
    logic               chr_from_rom;
  } cfg_t;

endpackage

/* rtl/cartridge_bank_mapper_irq.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with IRQ down counter: bank registers, address
// translation and a tick counter interrupt, one word in and one word out.
//
//   channel   direction  handshake         payload
//   in_       input      in_valid/in_stall kind, reg_index, write_data, bus_address
//   out_      output     out_valid/out_stall irq_line, mapped_address, mirroring,
//                                          chr_in_rom
//   cfg_      input      cfg_valid/cfg_ready index, data
//
// An accepted input word is registered in the input register, and the core
// update writes its result into the output queue, from which it can leave.
// One word is accepted every cycle while in_stall is low; the three-entry
// result queue sets how far the input runs ahead of a stalled output. Reset
// is synchronous and active low and needs no sweep. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [3:0]                   in_reg_index,
  input  logic [7:0]                   in_write_data,
  input  logic [cbm_pkg::ADDR_W-1:0]   in_bus_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_irq_line,
  output logic [cbm_pkg::MAP_W-1:0]    out_mapped_address,
  output logic [1:0]                   out_mirroring,
  output logic                         out_chr_in_rom,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [3:0]                   cfg_index,
  input  logic [cbm_pkg::COUNT_W-1:0]  cfg_data
);
  import cbm_pkg::*;

  logic                  in_accept;
  logic                  s1_valid_r;
  item_t                 s1_item_r;
  cfg_t                  cfg_r;
  logic                  res_valid;
  result_t               res;
  result_t               q_data;
  logic [OUTQ_CNT_W-1:0] q_level;
  logic [OUTQ_CNT_W:0]   reserved;

  assign cfg_ready = 1'b1;
  assign reserved  = {1'b0, q_level} + (OUTQ_CNT_W + 1)'(s1_valid_r);
  assign in_stall  = (reserved >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      cfg_r.prg_bank_count <= PRG_COUNT_RESET;
      cfg_r.chr_from_rom   <= 1'b1;
    end else begin
      s1_valid_r <= in_accept;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_BANK_COUNT) begin
          cfg_r.prg_bank_count <= cfg_data;
        end else if (cfg_index == CFG_CHR_FROM_ROM) begin
          cfg_r.chr_from_rom <= cfg_data[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind        <= kind_t'(in_kind);
      s1_item_r.reg_index   <= in_reg_index;
      s1_item_r.write_data  <= in_write_data;
      s1_item_r.bus_address <= in_bus_address;
    end
  end

  cbm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  cbm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data),
    .level     (q_level)
  );

  assign out_irq_line       = q_data.irq_line;
  assign out_mapped_address = q_data.mapped_address;
  assign out_mirroring      = q_data.mirroring;
  assign out_chr_in_rom     = q_data.chr_in_rom;

endmodule

/* rtl/cbm_core.sv */
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state and the combinational update and address translation of a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cartridge_bank_mapper_irq_macros.svh"

module cbm_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  cbm_pkg::item_t  item,
  input  cbm_pkg::cfg_t   cfg,
  output logic            res_valid,
  output cbm_pkg::result_t res
);
  import cbm_pkg::*;

  logic [BANK_W-1:0] chr_bank_r [CHR_SLOTS];
  logic [BANK_W-1:0] chr_bank_nxt [CHR_SLOTS];
  logic [BANK_W-1:0] prg_bank_r, prg_bank_nxt;
  logic [1:0]        mirror_r, mirror_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic              irq_pend_r, irq_pend_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic [CTR_W-1:0]  ctr_dec;
  logic [COUNT_W-1:0] count_m1;
  logic [BANK_W-1:0] bank_mask;
  logic [BANK_W-1:0] prg_sel;
  logic [SLOT_W-1:0] slot;
  logic [MAP_W-1:0]  mapped;

  assign ctr_dec   = ctr_r - CTR_W'(1);
  assign count_m1  = cfg.prg_bank_count - COUNT_W'(1);
  assign bank_mask = count_m1[BANK_W-1:0];
  assign prg_sel   = item.bus_address[PRG_OFS_W] ? bank_mask : (prg_bank_r & bank_mask);
  assign slot      = item.bus_address[CHR_OFS_W +: SLOT_W];

  always_comb begin
    chr_bank_nxt = chr_bank_r;
    prg_bank_nxt = prg_bank_r;
    mirror_nxt   = mirror_r;
    irq_en_nxt   = irq_en_r;
    irq_pend_nxt = irq_pend_r;
    ctr_nxt      = ctr_r;
    mapped       = '0;
    case (item.kind)
      KIND_WRITE: begin
        if (item.reg_index < REG_PRG_BANK) begin
          chr_bank_nxt[item.reg_index[SLOT_W-1:0]] = item.write_data;
        end else begin
          case (item.reg_index)
            REG_PRG_BANK: prg_bank_nxt = item.write_data;
            REG_MIRROR:   mirror_nxt = item.write_data[1:0];
            REG_IRQ_CTRL: begin
              irq_en_nxt   = item.write_data[0];
              irq_pend_nxt = 1'b0;
            end
            REG_CTR_LOW:  ctr_nxt = {ctr_r[CTR_W-1:8], item.write_data};
            REG_CTR_HIGH: ctr_nxt = {item.write_data, ctr_r[7:0]};
            default: ;
          endcase
        end
      end
      KIND_TICK: begin
        if (irq_en_r) begin
          ctr_nxt = ctr_dec;
          if (ctr_dec == '0) begin
            irq_pend_nxt = 1'b1;
            irq_en_nxt   = 1'b0;
          end
        end
      end
      KIND_PRG: begin
        mapped = MAP_W'({prg_sel, item.bus_address[PRG_OFS_W-1:0]});
      end
      KIND_CHR: begin
        mapped = MAP_W'({chr_bank_r[slot], item.bus_address[CHR_OFS_W-1:0]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_bank_r[i] <= BANK_W'(i);
      end
      prg_bank_r <= '0;
      mirror_r   <= '0;
      irq_en_r   <= 1'b0;
      irq_pend_r <= 1'b0;
      ctr_r      <= '0;
    end else if (item_valid) begin
      chr_bank_r <= chr_bank_nxt;
      prg_bank_r <= prg_bank_nxt;
      mirror_r   <= mirror_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_pend_r <= irq_pend_nxt;
      ctr_r      <= ctr_nxt;
    end
  end

  assign res_valid          = item_valid;
  assign res.irq_line       = irq_pend_nxt;
  assign res.mapped_address = mapped;
  assign res.mirroring      = mirror_nxt;
  assign res.chr_in_rom     = cfg.chr_from_rom;

  `CBM_ASSERT_NOW(a_pend_excl_en, 1'b1, !(irq_pend_r && irq_en_r))
  `CBM_ASSERT_NEXT(a_tick_fires, item_valid && item.kind == KIND_TICK && irq_en_r && ctr_r == CTR_W'(1), irq_pend_r && !irq_en_r)
  `CBM_ASSERT_NEXT(a_ctrl_clears, item_valid && item.kind == KIND_WRITE && item.reg_index == REG_IRQ_CTRL, !irq_pend_r)

endmodule

/* rtl/cbm_outq.sv */
// ----------------------------------------------------------------------------
// cbm_outq
// Small result queue that holds finished words while the output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cartridge_bank_mapper_irq_macros.svh"

module cbm_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  cbm_pkg::result_t                  push_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbm_pkg::result_t                  out_data,
  output logic [cbm_pkg::OUTQ_CNT_W-1:0]    level
);
  import cbm_pkg::*;

  result_t               mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];
  assign level     = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + OUTQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + OUTQ_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + OUTQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CBM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH))
  `CBM_ASSERT_NOW(a_no_overflow, push, cnt_r != OUTQ_CNT_W'(OUTQ_DEPTH) || pop)
  `CBM_ASSERT_NEXT(a_drain, pop && !push, cnt_r == $past(cnt_r) - OUTQ_CNT_W'(1))

endmodule

/* tb/cartridge_bank_mapper_irq_tb.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_tb
// Self-checking bench for the cartridge bank mapper. Each word sent is run
// through a local model of the bank registers, address windows and IRQ
// counter. Each result word is compared field by field with the oldest
// prediction. Directed tests cover reset values, the register map, the IRQ
// countdown and extreme bank counts. Random traffic then runs in phases with
// different bank counts and different amounts of sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_tb;
  import cbm_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_WORDS   = 500;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [1:0]          in_kind        = '0;
  logic [3:0]          in_reg_index   = '0;
  logic [7:0]          in_write_data  = '0;
  logic [ADDR_W-1:0]   in_bus_address = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic                out_irq_line;
  logic [MAP_W-1:0]    out_mapped_address;
  logic [1:0]          out_mirroring;
  logic                out_chr_in_rom;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_index      = '0;
  logic [COUNT_W-1:0]  cfg_data       = '0;

  // Model of the mapper state and configuration.
  logic [7:0]          chr_bank_m [CHR_SLOTS];
  logic [7:0]          prg_bank_m     = '0;
  logic [1:0]          mirror_m       = '0;
  logic                irq_en_m       = 1'b0;
  logic [CTR_W-1:0]    irq_ctr_m      = '0;
  logic                irq_pend_m     = 1'b0;
  logic [COUNT_W-1:0]  bank_count_m   = PRG_COUNT_RESET;
  logic                chr_rom_m      = 1'b1;

  result_t             bus_results_q [$];
  result_t             oldest_result;
  int                  words_sent     = 0;
  int                  mismatches     = 0;
  int                  cycle_count    = 0;
  int                  idle_pct       = 0;
  int                  stall_pct      = 0;

  cartridge_bank_mapper_irq i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_reg_index       (in_reg_index),
    .in_write_data      (in_write_data),
    .in_bus_address     (in_bus_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_irq_line       (out_irq_line),
    .out_mapped_address (out_mapped_address),
    .out_mirroring      (out_mirroring),
    .out_chr_in_rom     (out_chr_in_rom),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t map_bus_word(item_t w);
    result_t             r;
    logic [COUNT_W-1:0]  count_less;
    logic [7:0]          mask;
    logic [7:0]          bank;
    r = '0;
    case (w.kind)
      KIND_WRITE: begin
        if (w.reg_index < REG_PRG_BANK) begin
          chr_bank_m[w.reg_index[SLOT_W-1:0]] = w.write_data;
        end else begin
          case (w.reg_index)
            REG_PRG_BANK: prg_bank_m = w.write_data;
            REG_MIRROR:   mirror_m = w.write_data[1:0];
            REG_IRQ_CTRL: begin
              irq_en_m   = w.write_data[0];
              irq_pend_m = 1'b0;
            end
            REG_CTR_LOW:  irq_ctr_m[7:0] = w.write_data;
            REG_CTR_HIGH: irq_ctr_m[15:8] = w.write_data;
            default: ;
          endcase
        end
      end
      KIND_TICK: begin
        if (irq_en_m) begin
          irq_ctr_m = irq_ctr_m - 1'b1;
          if (irq_ctr_m == '0) begin
            irq_pend_m = 1'b1;
            irq_en_m   = 1'b0;
          end
        end
      end
      KIND_PRG: begin
        count_less = bank_count_m - 1'b1;
        mask = count_less[7:0];
        bank = w.bus_address[14] ? mask : (prg_bank_m & mask);
        r.mapped_address = {bank, w.bus_address[PRG_OFS_W-1:0]};
      end
      default: begin
        r.mapped_address = MAP_W'({chr_bank_m[w.bus_address[12:10]],
                                   w.bus_address[CHR_OFS_W-1:0]});
      end
    endcase
    r.irq_line   = irq_pend_m;
    r.mirroring  = mirror_m;
    r.chr_in_rom = chr_rom_m;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %0h", $time,
                 out_mapped_address);
        mismatches++;
      end else begin
        oldest_result = bus_results_q.pop_front();
        check_field("irq_line", 32'(oldest_result.irq_line), 32'(out_irq_line));
        check_field("mapped_address", 32'(oldest_result.mapped_address),
                    32'(out_mapped_address));
        check_field("mirroring", 32'(oldest_result.mirroring), 32'(out_mirroring));
        check_field("chr_in_rom", 32'(oldest_result.chr_in_rom), 32'(out_chr_in_rom));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic pause_sender();
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(kind_t k, logic [3:0] idx, logic [7:0] data,
                           logic [ADDR_W-1:0] addr);
    item_t w;
    w.kind        = k;
    w.reg_index   = idx;
    w.write_data  = data;
    w.bus_address = addr;
    pause_sender();
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_reg_index   <= idx;
    in_write_data  <= data;
    in_bus_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_results_q.push_back(map_bus_word(w));
    words_sent++;
  endtask

  task automatic send_random_word();
    send_word(kind_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom), 15'($urandom));
  endtask

  task automatic send_write(logic [3:0] idx, logic [7:0] data);
    send_word(KIND_WRITE, idx, data, 15'($urandom));
  endtask

  task automatic send_translate(kind_t k, logic [ADDR_W-1:0] addr);
    send_word(k, 4'($urandom), 8'($urandom), addr);
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 4'($urandom), 8'($urandom), 15'($urandom));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PRG_BANK_COUNT) begin
      bank_count_m = data;
    end else if (idx == CFG_CHR_FROM_ROM) begin
      chr_rom_m = data[0];
    end
  endtask

  task automatic set_mapper_config(logic [COUNT_W-1:0] count, logic chr_rom);
    wait_for_results();
    write_cfg(CFG_PRG_BANK_COUNT, count);
    write_cfg(CFG_CHR_FROM_ROM, COUNT_W'(chr_rom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_translate(KIND_CHR, 15'h1FFF);
    send_translate(KIND_PRG, 15'h0000);
    send_translate(KIND_PRG, 15'h7FFF);
  endtask

  task automatic test_bank_registers();
    send_write(4'd0, 8'hFF);
    send_write(REG_PRG_BANK, 8'hFF);
    send_write(REG_MIRROR, 8'hFE);
    send_write(4'd13, 8'hFF);
    send_translate(KIND_CHR, 15'h6000);
    send_translate(KIND_PRG, 15'h3FFF);
    send_write(REG_MIRROR, 8'h03);
  endtask

  task automatic test_irq_counter();
    send_write(REG_CTR_LOW, 8'h02);
    send_write(REG_CTR_HIGH, 8'h00);
    send_write(REG_IRQ_CTRL, 8'h01);
    send_tick();
    send_tick();
    send_tick();
    send_write(REG_IRQ_CTRL, 8'h00);
  endtask

  task automatic test_bank_count_extremes();
    set_mapper_config(COUNT_W'(0), 1'b0);
    send_translate(KIND_PRG, 15'h3ABC);
    set_mapper_config(COUNT_W'(1), 1'b1);
    send_translate(KIND_PRG, 15'h7123);
    set_mapper_config(COUNT_W'(3), 1'b0);
    send_translate(KIND_PRG, 15'($urandom));
    set_mapper_config(COUNT_W'(256), 1'b1);
    send_translate(KIND_PRG, 15'($urandom));
  endtask

  // A well-formed countdown: load the counter, enable it and send it a run of ticks,
  // with other traffic mixed in and an occasional acknowledge at the end.
  task automatic run_irq_countdown();
    logic [CTR_W-1:0] start;
    int               n;
    if ($urandom_range(0, 7) == 0) begin
      start = CTR_W'($urandom);
    end else begin
      start = CTR_W'($urandom_range(0, 20));
    end
    n = $urandom_range(1, 24);
    send_write(REG_CTR_LOW, start[7:0]);
    send_write(REG_CTR_HIGH, start[15:8]);
    send_write(REG_IRQ_CTRL, 8'($urandom) | 8'h01);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        send_tick();
      end else begin
        send_random_word();
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      send_write(REG_IRQ_CTRL, 8'($urandom));
    end
  endtask

  task automatic run_random_phase(int idle, int stall, logic [COUNT_W-1:0] count,
                                  logic chr_rom);
    int first;
    set_mapper_config(count, chr_rom);
    idle_pct  = idle;
    stall_pct = stall;
    first     = words_sent;
    while (words_sent - first < PHASE_WORDS) begin
      if ($urandom_range(0, 9) < 3) begin
        run_irq_countdown();
      end else begin
        send_random_word();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, COUNT_W'(2), 1'b0);
    run_random_phase(74, 0, COUNT_W'(1) << $urandom_range(1, 8), 1'b1);
    run_random_phase(0, 74, COUNT_W'(511), 1'b0);
    run_random_phase(29, 29, COUNT_W'(256), 1'b1);
  endtask

  initial begin
    foreach (chr_bank_m[i]) chr_bank_m[i] = 8'(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_bank_registers();
    test_irq_counter();
    test_bank_count_extremes();
    test_random_traffic();
    wait_for_results();
    if (mismatches == 0 && bus_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
